[hw/rtl/hcb_pkg.sv]
`default_nettype none
package hcb_pkg;

	localparam int MAX_VERTICES = 32;
	localparam int VW = 6;
	localparam int LW = $clog2(MAX_VERTICES);

	localparam logic CMD_ADD_EDGE = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	typedef logic [VW-1:0] vtx_t;
	typedef logic [LW-1:0] lvl_t;
	typedef logic [MAX_VERTICES-1:0] vmask_t;

	typedef struct packed {
		logic edge_wr;
		logic init;
		logic push;
		logic pop;
		logic emit_vtx;
		logic emit_close;
		logic emit_none;
	} hcb_cmd_t;

	typedef struct packed {
		logic cand_any;
		logic full_path;
		logic close_ok;
		logic at_root;
		logic count_zero;
		logic emit_end;
		logic out_free;
	} hcb_sts_t;

endpackage
`default_nettype wire

[hw/rtl/hamiltonian_cycle_backtrack_top.sv]
// Hamiltonian cycle search by depth-first backtracking from vertex 1 over an
// adjacency store of up to 32 vertices, cleared at reset. An edge-add transfer
// (tuser low) is written into the store as it is taken, so edges can stream in
// back to back. A search transfer (tuser high) holds the input off until its
// last result has been loaded into the output register: each step of the
// backtracking walk (every extension or retreat of the path) goes through the
// shared candidate finder, then a final verdict is reached, and the cycle is
// emitted one vertex per transfer, n + 1 results ending with vertex 1 and
// tlast, at one per cycle when the sink is ready. If no cycle exists a single
// transfer with tuser low, vertex 0 and tlast is emitted.
// Write vertex_count only while no search is in progress.
`default_nettype none
module hamiltonian_cycle_backtrack_top import hcb_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // vertex_a [5:0], vertex_b [11:6], zero fill
	input  wire logic        s_tuser,  // command
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // path_vertex [5:0], zero fill
	output logic             m_tuser,  // found
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic [5:0]  cfg_wdata
);

	hcb_cmd_t cmd;
	hcb_sts_t sts;
	vtx_t     out_vertex;

	hcb_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_command(s_tuser),
		.in_ready  (s_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	hcb_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.vertex_a (s_tdata[5:0]),
		.vertex_b (s_tdata[11:6]),
		.cmd      (cmd),
		.sts      (sts),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_vertex (out_vertex),
		.m_found  (m_tuser),
		.m_last   (m_tlast)
	);

	assign m_tdata = {2'b00, out_vertex};

	a_one_command: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("More than one datapath command in a cycle.");

	a_push_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !sts.full_path)
		else $error("Path extended beyond the vertex count.");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_vtx || cmd.emit_close || cmd.emit_none) |-> sts.out_free)
		else $error("Result loaded over one not yet transferred.");

	a_edge_on_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.edge_wr |-> (s_tvalid && s_tready))
		else $error("Edge written without an input transfer.");

endmodule
`default_nettype wire

[hw/rtl/hcb_datapath.sv]
`default_nettype none
module hcb_datapath import hcb_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cfg_we,
	input  wire vtx_t     cfg_wdata,
	input  wire vtx_t     vertex_a,
	input  wire vtx_t     vertex_b,
	input  wire hcb_cmd_t cmd,
	output hcb_sts_t      sts,
	input  wire logic     m_tready,
	output logic          m_tvalid,
	output vtx_t          m_vertex,
	output logic          m_found,
	output logic          m_last
);

	vtx_t   vcount_q;
	vmask_t adj_q [MAX_VERTICES];
	vtx_t   stack_q [MAX_VERTICES];
	vmask_t visited_q;
	lvl_t   lvl_q;
	lvl_t   cur_q;
	vtx_t   after_q;
	vtx_t   idx_q;
	logic   out_valid_q;
	vtx_t   out_vertex_q;
	logic   out_found_q;
	logic   out_last_q;

	vtx_t   n;
	vmask_t in_use;
	vmask_t above;
	vmask_t row;
	vmask_t cand;
	vmask_t lowbit;
	lvl_t   low_idx;
	vtx_t   next_vtx;
	lvl_t   rd_addr;
	vtx_t   rd_vtx;
	lvl_t   a_i;
	lvl_t   b_i;
	logic   edge_ok;

	always_comb begin
		n = (vcount_q > VW'(MAX_VERTICES)) ? VW'(MAX_VERTICES) : vcount_q;
		for (int j = 0; j < MAX_VERTICES; j++) begin
			in_use[j] = VW'(j) < n;
			above[j] = VW'(j) >= after_q;
		end
		row = adj_q[cur_q];
		cand = row & in_use & ~visited_q & above;
		lowbit = cand & (~cand + vmask_t'(1));
		low_idx = '0;
		for (int j = 0; j < MAX_VERTICES; j++) begin
			if (lowbit[j]) begin
				low_idx = low_idx | LW'(j);
			end
		end
		next_vtx = VW'(low_idx) + VW'(1);
		a_i = LW'(vertex_a - VW'(1));
		b_i = LW'(vertex_b - VW'(1));
		edge_ok = (vertex_a != '0) && (vertex_a <= n) && (vertex_b != '0) && (vertex_b <= n);
	end

	always_comb begin
		rd_addr = cmd.emit_vtx ? idx_q[LW-1:0] : lvl_q - LW'(1);
		rd_vtx = stack_q[rd_addr];
	end

	always_comb begin
		sts.cand_any = |cand;
		sts.full_path = (VW'(lvl_q) + VW'(1)) == n;
		sts.close_ok = row[0];
		sts.at_root = lvl_q == '0;
		sts.count_zero = n == '0;
		sts.emit_end = idx_q == n;
		sts.out_free = !out_valid_q || m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VW'(MAX_VERTICES);
		end else if (cfg_we) begin
			vcount_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < MAX_VERTICES; r++) begin
				adj_q[r] <= '0;
			end
		end else if (cmd.edge_wr && edge_ok) begin
			adj_q[a_i][b_i] <= 1'b1;
			adj_q[b_i][a_i] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			stack_q[0] <= VW'(1);
		end else if (cmd.push) begin
			stack_q[lvl_q + LW'(1)] <= next_vtx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
			lvl_q <= '0;
			cur_q <= '0;
			after_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.init) begin
				visited_q <= vmask_t'(1);
				lvl_q <= '0;
				cur_q <= '0;
				after_q <= '0;
				idx_q <= '0;
			end else if (cmd.push) begin
				visited_q <= visited_q | lowbit;
				lvl_q <= lvl_q + LW'(1);
				cur_q <= low_idx;
				after_q <= '0;
			end else if (cmd.pop) begin
				visited_q <= visited_q & ~(vmask_t'(1) << cur_q);
				lvl_q <= lvl_q - LW'(1);
				cur_q <= LW'(rd_vtx - VW'(1));
				after_q <= VW'(cur_q) + VW'(1);
			end
			if (cmd.emit_vtx) begin
				idx_q <= idx_q + VW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_vtx || cmd.emit_close || cmd.emit_none) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_vtx) begin
			out_vertex_q <= rd_vtx;
			out_found_q <= 1'b1;
			out_last_q <= 1'b0;
		end else if (cmd.emit_close) begin
			out_vertex_q <= VW'(1);
			out_found_q <= 1'b1;
			out_last_q <= 1'b1;
		end else if (cmd.emit_none) begin
			out_vertex_q <= '0;
			out_found_q <= 1'b0;
			out_last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_vertex = out_vertex_q;
	assign m_found = out_found_q;
	assign m_last = out_last_q;

endmodule
`default_nettype wire

[hw/rtl/hcb_controller.sv]
`default_nettype none
module hcb_controller import hcb_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     in_command,
	output logic          in_ready,
	input  wire hcb_sts_t sts,
	output hcb_cmd_t      cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;
	localparam logic [1:0] ST_NONE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		in_ready = state_q == ST_IDLE;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_command == CMD_ADD_EDGE) begin
						cmd.edge_wr = 1'b1;
					end else if (sts.count_zero) begin
						state_d = ST_NONE;
					end else begin
						cmd.init = 1'b1;
						state_d = ST_SEARCH;
					end
				end
			end
			ST_SEARCH: begin
				priority if (sts.cand_any && !sts.full_path) begin
					cmd.push = 1'b1;
				end else if (sts.full_path && sts.close_ok) begin
					state_d = ST_EMIT;
				end else if (sts.at_root) begin
					state_d = ST_NONE;
				end else begin
					cmd.pop = 1'b1;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					if (sts.emit_end) begin
						cmd.emit_close = 1'b1;
						state_d = ST_IDLE;
					end else begin
						cmd.emit_vtx = 1'b1;
					end
				end
			end
			ST_NONE: begin
				if (sts.out_free) begin
					cmd.emit_none = 1'b1;
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

[tb/tb_hamiltonian_cycle_backtrack_top.sv]
`default_nettype none

class cycle_scoreboard;
	typedef struct packed {
		logic       found;
		logic [5:0] vtx;
		logic       last;
	} cycle_step_t;

	logic [31:0] adj_rows [32];
	logic [5:0] walk [33];
	int unsigned count_reg;
	cycle_step_t expected_path [$];
	int failures;

	function new();
		foreach (adj_rows[i]) adj_rows[i] = '0;
		count_reg = 32;
		failures = 0;
	endfunction

	function logic [31:0] below(int unsigned k);
		logic [63:0] m;
		m = (64'd1 << k) - 64'd1;
		return m[31:0];
	endfunction

	function logic [31:0] row_of(int unsigned v);
		if (v < 1 || v > hcb_pkg::MAX_VERTICES)
			return '0;
		return adj_rows[v - 1];
	endfunction

	function void add_step(logic found, logic [5:0] vtx, logic last);
		cycle_step_t s;
		s.found = found;
		s.vtx = vtx;
		s.last = last;
		expected_path.insert(expected_path.size(), s);
	endfunction

	// Depth-first walk from vertex 1, lowest unvisited neighbor first, resuming above
	// the choice last tried at each depth. Leaves the path in walk[].
	function logic walk_cycle(int unsigned n);
		logic [31:0] in_use;
		logic [31:0] visited;
		logic [31:0] cand;
		logic [31:0] cur_row;
		int unsigned after;
		int unsigned lvl;
		int unsigned v;
		logic done;
		logic hit;
		in_use = below(n);
		foreach (walk[i]) walk[i] = '0;
		walk[0] = 6'd1;
		visited = 32'd1;
		after = 0;
		lvl = 0;
		done = 1'b0;
		hit = 1'b0;
		while (!done) begin
			cur_row = row_of(32'(walk[lvl]));
			cand = cur_row & in_use & ~visited & ~below(after);
			if (cand != '0 && lvl + 1 < n) begin
				v = 1;
				while (!cand[v - 1])
					v++;
				lvl++;
				walk[lvl] = v[5:0];
				visited[v - 1] = 1'b1;
				after = 0;
			end else if (lvl + 1 == n && cur_row[0]) begin
				hit = 1'b1;
				done = 1'b1;
			end else if (lvl == 0) begin
				done = 1'b1;
			end else begin
				after = 32'(walk[lvl]);
				visited[after - 1] = 1'b0;
				walk[lvl] = '0;
				lvl--;
			end
		end
		return hit;
	endfunction

	function void note_input(logic cmd, logic [5:0] a, logic [5:0] b);
		int unsigned n;
		n = (count_reg > hcb_pkg::MAX_VERTICES) ? hcb_pkg::MAX_VERTICES : count_reg;
		if (cmd == hcb_pkg::CMD_ADD_EDGE) begin
			if (a >= 1 && a <= n && b >= 1 && b <= n) begin
				adj_rows[a - 1][b - 1] = 1'b1;
				adj_rows[b - 1][a - 1] = 1'b1;
			end
		end else if (n == 0 || !walk_cycle(n)) begin
			add_step(1'b0, 6'd0, 1'b1);
		end else begin
			for (int unsigned i = 0; i < n; i++)
				add_step(1'b1, walk[i], 1'b0);
			add_step(1'b1, 6'd1, 1'b1);
		end
	endfunction

	function void check_result(logic found, logic [5:0] vtx, logic last);
		cycle_step_t s;
		if (expected_path.size() == 0) begin
			$error("unexpected result: found %0d path_vertex %0d last_of_run %0d",
				found, vtx, last);
			failures++;
			return;
		end
		s = expected_path.pop_front();
		if (found !== s.found) begin
			$error("found: expected %0d, got %0d", s.found, found);
			failures++;
		end
		if (vtx !== s.vtx) begin
			$error("path_vertex: expected %0d, got %0d", s.vtx, vtx);
			failures++;
		end
		if (last !== s.last) begin
			$error("last_of_run: expected %0d, got %0d", s.last, last);
			failures++;
		end
	endfunction
endclass

module tb_hamiltonian_cycle_backtrack_top;
	import hcb_pkg::*;

	localparam int IDLE_LIMIT = 300000;
	localparam int SETTLE = 8;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        cfg_we;
	logic [5:0]  cfg_wdata;

	cycle_scoreboard sb = new();
	logic sender_burst = 1'b0;
	logic sink_burst = 1'b0;
	int idle_cycles = 0;
	int phase_plan [16] = '{20, 4, 6, 3, 7, 2, 5, 8, 1, 6, 0, 7, 63, 5, 3, 4};

	hamiltonian_cycle_backtrack_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_input(s_tuser, s_tdata[5:0], s_tdata[11:6]);
			if (m_tvalid && m_tready)
				sb.check_result(m_tuser, m_tdata[5:0], m_tlast);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("hamiltonian_cycle_backtrack_top test failed");
				$finish;
			end
		end
	end

	initial begin
		int unsigned stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = sink_burst ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
		end
	end

	task automatic send_item(input logic cmd, input logic [5:0] a, input logic [5:0] b);
		int unsigned gap;
		gap = sender_burst ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {4'b0000, b, a};
		do @(posedge clk); while (s_tready !== 1'b1);
	endtask

	task automatic wait_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expected_path.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_count(input logic [5:0] value);
		wait_results();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.count_reg = 32'(value);
	endtask

	task automatic search();
		send_item(CMD_SEARCH, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
	endtask

	task automatic build_ring();
		write_count(6'd32);
		sender_burst = 1'b0;
		for (int v = 1; v <= 32; v++) begin
			if ($urandom_range(0, 1))
				send_item(CMD_ADD_EDGE, 6'(v), 6'(v % 32 + 1));
			else
				send_item(CMD_ADD_EDGE, 6'(v % 32 + 1), 6'(v));
		end
		search();
		search();
	endtask

	task automatic run_phase(input int unsigned cfg, input int items);
		int unsigned n;
		int unsigned top;
		int unsigned pick;
		logic [5:0] bad;
		logic [5:0] other;
		write_count(6'(cfg));
		sender_burst = ($urandom_range(0, 3) == 0);
		sink_burst = ($urandom_range(0, 3) == 0);
		n = (cfg > MAX_VERTICES) ? MAX_VERTICES : cfg;
		top = (n < 8) ? n : 8;
		repeat (items) begin
			pick = $urandom_range(0, 99);
			if (pick < 16) begin
				if ($urandom_range(0, 7) == 0)
					wait_results();
				search();
			end else if (pick < 26 || top == 0) begin
				// Edges with an endpoint of 0 or above the count must leave the store alone.
				bad = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom_range(n + 1, 63));
				other = 6'($urandom_range(0, 63));
				if ($urandom_range(0, 1))
					send_item(CMD_ADD_EDGE, bad, other);
				else
					send_item(CMD_ADD_EDGE, other, bad);
			end else begin
				send_item(CMD_ADD_EDGE, 6'($urandom_range(1, top)),
					6'($urandom_range(1, top)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		search();
		send_item(CMD_ADD_EDGE, 6'd0, 6'd1);
		send_item(CMD_ADD_EDGE, 6'd1, 6'd0);
		send_item(CMD_ADD_EDGE, 6'd63, 6'd63);
		send_item(CMD_ADD_EDGE, 6'd33, 6'd2);
		send_item(CMD_ADD_EDGE, 6'd1, 6'd40);
		send_item(CMD_ADD_EDGE, 6'd1, 6'd1);
		send_item(CMD_SEARCH, 6'd63, 6'd63);
		write_count(6'd1);
		send_item(CMD_SEARCH, 6'd21, 6'd42);
		send_item(CMD_ADD_EDGE, 6'd1, 6'd2);
		send_item(CMD_SEARCH, 6'd0, 6'd0);
		write_count(6'd0);
		search();
		send_item(CMD_ADD_EDGE, 6'd1, 6'd1);
		write_count(6'd3);
		send_item(CMD_ADD_EDGE, 6'd2, 6'd1);
		send_item(CMD_ADD_EDGE, 6'd2, 6'd3);
		send_item(CMD_ADD_EDGE, 6'd3, 6'd1);
		search();
		write_count(6'd4);
		search();
		write_count(6'd2);
		search();
		write_count(6'd63);
		search();

		foreach (phase_plan[i]) begin
			if (i == 7)
				build_ring();
			run_phase(phase_plan[i], 27);
		end

		wait_results();
		if (sb.failures == 0 && sb.expected_path.size() == 0)
			$display("hamiltonian_cycle_backtrack_top test passed");
		else
			$display("hamiltonian_cycle_backtrack_top test failed");
		$finish;
	end
endmodule

`default_nettype wire
